// ===== hdl/nearest_downscale_pixel_packer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the downscaler and pixel packer
// Clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_DOWNSCALE_PIXEL_PACKER_CORE_MACROS_SVH
`define NEAREST_DOWNSCALE_PIXEL_PACKER_CORE_MACROS_SVH

// Same-cycle implication
`define NDPP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ndpp check failed");

// Next-cycle implication
`define NDPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ndpp check failed");

`endif

// ===== hdl/ndpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ndpp_pkg
// Types and constants shared by the downscaler and pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ndpp_pkg;

    localparam int PIXELS_PER_WORD = 4;
    localparam int MAX_SOURCE_SIZE = 1024;
    localparam int LANE_W          = $clog2(PIXELS_PER_WORD);

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_WORDS    = 3'd2;
    localparam logic [2:0] REG_DEST_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_STRIDE_SHIFT  = 3'd4;

    localparam logic [10:0] RST_SOURCE_WIDTH  = 11'd320;
    localparam logic [10:0] RST_SOURCE_HEIGHT = 11'd200;
    localparam logic [6:0]  RST_DEST_WORDS    = 7'd24;
    localparam logic [8:0]  RST_DEST_HEIGHT   = 9'd64;
    localparam logic [3:0]  RST_STRIDE_SHIFT  = 4'd7;

    // clamped geometry as seen by the scaler
    typedef struct packed {
        logic [10:0] src_w;     // 1..MAX_SOURCE_SIZE
        logic [10:0] src_h;     // 1..MAX_SOURCE_SIZE
        logic [8:0]  dst_w;     // destination pixels per row, 4..256
        logic [8:0]  dst_h;     // 1..256
        logic [3:0]  shift_m2;  // row stride shift minus two, 0..8
    } t_cfg;

    typedef struct packed {
        logic        emit;
        logic [31:0] word;
        logic [15:0] addr;
        logic        done;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ndpp_cfg.sv =====
// ----------------------------------------------------------------------------
// ndpp_cfg
// APB register file with range clamping of the geometry registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ndpp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ndpp_pkg::t_cfg     o_cfg
);
    import ndpp_pkg::*;

    logic [10:0] r_src_w;
    logic [10:0] r_src_h;
    logic [6:0]  r_dst_words;
    logic [8:0]  r_dst_h;
    logic [3:0]  r_shift;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [6:0]  words_c;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= RST_SOURCE_WIDTH;
            r_src_h     <= RST_SOURCE_HEIGHT;
            r_dst_words <= RST_DEST_WORDS;
            r_dst_h     <= RST_DEST_HEIGHT;
            r_shift     <= RST_STRIDE_SHIFT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SOURCE_WIDTH:  r_src_w     <= pwdata[10:0];
                REG_SOURCE_HEIGHT: r_src_h     <= pwdata[10:0];
                REG_DEST_WORDS:    r_dst_words <= pwdata[6:0];
                REG_DEST_HEIGHT:   r_dst_h     <= pwdata[8:0];
                REG_STRIDE_SHIFT:  r_shift     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SOURCE_WIDTH:  prdata = {21'd0, r_src_w};
            REG_SOURCE_HEIGHT: prdata = {21'd0, r_src_h};
            REG_DEST_WORDS:    prdata = {25'd0, r_dst_words};
            REG_DEST_HEIGHT:   prdata = {23'd0, r_dst_h};
            REG_STRIDE_SHIFT:  prdata = {28'd0, r_shift};
            default:           prdata = 32'd0;
        endcase
    end

    // saturate each register into its legal range
    always_comb begin
        if (r_src_w == 11'd0)                         o_cfg.src_w = 11'd1;
        else if (r_src_w > 11'(MAX_SOURCE_SIZE))      o_cfg.src_w = 11'(MAX_SOURCE_SIZE);
        else                                          o_cfg.src_w = r_src_w;

        if (r_src_h == 11'd0)                         o_cfg.src_h = 11'd1;
        else if (r_src_h > 11'(MAX_SOURCE_SIZE))      o_cfg.src_h = 11'(MAX_SOURCE_SIZE);
        else                                          o_cfg.src_h = r_src_h;

        if (r_dst_words == 7'd0)                      words_c = 7'd1;
        else if (r_dst_words > 7'd64)                 words_c = 7'd64;
        else                                          words_c = r_dst_words;
        o_cfg.dst_w = {words_c, 2'b00};

        if (r_dst_h == 9'd0)                          o_cfg.dst_h = 9'd1;
        else if (r_dst_h > 9'd256)                    o_cfg.dst_h = 9'd256;
        else                                          o_cfg.dst_h = r_dst_h;

        if (r_shift < 4'd2)                           o_cfg.shift_m2 = 4'd0;
        else if (r_shift > 4'd10)                     o_cfg.shift_m2 = 4'd8;
        else                                          o_cfg.shift_m2 = r_shift - 4'd2;
    end

endmodule

`default_nettype wire

// ===== hdl/ndpp_step.sv =====
// ----------------------------------------------------------------------------
// ndpp_step
// Scan position, error accumulators and pack buffer; one pixel per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module ndpp_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_pixel,
    input  logic                i_start,
    input  ndpp_pkg::t_cfg      i_cfg,
    output ndpp_pkg::t_result   o_result
);
    import ndpp_pkg::*;

    logic [9:0]  r_scol, n_scol, c_scol;
    logic [9:0]  r_srow, n_srow, c_srow;
    logic [12:0] r_cerr, n_cerr, c_cerr;
    logic [12:0] r_rerr, n_rerr, c_rerr;
    logic [8:0]  r_dcol, n_dcol, c_dcol;
    logic [8:0]  r_drow, n_drow, c_drow;
    logic [23:0] r_pack, n_pack, c_pack;

    logic              row_kept;
    logic              keep;
    logic [LANE_W-1:0] lane;
    logic              last_lane;
    logic [23:0]       pack_ins;
    logic [15:0]       row_off;
    logic              col_end;
    logic              frame_end;
    logic [14:0]       cerr_sum;
    logic [14:0]       rerr_sum;
    logic [12:0]       cerr_nx;
    logic [12:0]       rerr_nx;

    // a frame start beat sees the reset state
    always_comb begin
        c_scol = i_start ? '0 : r_scol;
        c_srow = i_start ? '0 : r_srow;
        c_cerr = i_start ? '0 : r_cerr;
        c_rerr = i_start ? '0 : r_rerr;
        c_dcol = i_start ? '0 : r_dcol;
        c_drow = i_start ? '0 : r_drow;
        c_pack = i_start ? '0 : r_pack;
    end

    assign row_kept  = (c_rerr < {4'd0, i_cfg.dst_h}) && (c_drow < i_cfg.dst_h);
    assign keep      = row_kept && (c_cerr < {4'd0, i_cfg.dst_w}) && (c_dcol < i_cfg.dst_w);
    assign lane      = c_dcol[LANE_W-1:0];
    assign last_lane = (lane == LANE_W'(PIXELS_PER_WORD - 1));

    always_comb begin
        pack_ins = c_pack;
        case (lane)
            2'd0:    pack_ins[7:0]   = i_pixel;
            2'd1:    pack_ins[15:8]  = i_pixel;
            2'd2:    pack_ins[23:16] = i_pixel;
            default: ;
        endcase
    end

    // a kept row is below 256 and the shift at most 8, so 16 bits hold it
    assign row_off = {7'd0, c_drow} << i_cfg.shift_m2;

    always_comb begin
        o_result.emit = keep && last_lane;
        o_result.word = {i_pixel, c_pack};
        o_result.addr = row_off + {9'd0, c_dcol[8:LANE_W]};
        o_result.done = (c_drow == i_cfg.dst_h - 9'd1) && (c_dcol == i_cfg.dst_w - 9'd1);
    end

    assign col_end   = ({1'b0, c_scol} + 11'd1) >= i_cfg.src_w;
    assign frame_end = ({1'b0, c_srow} + 11'd1) >= i_cfg.src_h;

    // error accumulators saturate at zero
    assign cerr_sum = {2'd0, c_cerr} + (keep ? {4'd0, i_cfg.src_w} : 15'd0);
    assign rerr_sum = {2'd0, c_rerr} + (row_kept ? {4'd0, i_cfg.src_h} : 15'd0);
    assign cerr_nx  = (cerr_sum > {6'd0, i_cfg.dst_w}) ?
                      13'(cerr_sum - {6'd0, i_cfg.dst_w}) : 13'd0;
    assign rerr_nx  = (rerr_sum > {6'd0, i_cfg.dst_h}) ?
                      13'(rerr_sum - {6'd0, i_cfg.dst_h}) : 13'd0;

    always_comb begin
        n_scol = c_scol + 10'd1;
        n_srow = c_srow;
        n_cerr = cerr_nx;
        n_rerr = c_rerr;
        n_dcol = keep ? c_dcol + 9'd1 : c_dcol;
        n_drow = c_drow;
        n_pack = c_pack;
        if (keep) begin
            n_pack = last_lane ? 24'd0 : pack_ins;
        end
        if (col_end) begin
            n_scol = '0;
            n_cerr = '0;
            n_dcol = '0;
            n_pack = '0;
            if (frame_end) begin
                n_srow = '0;
                n_rerr = '0;
                n_drow = '0;
            end else begin
                n_srow = c_srow + 10'd1;
                n_rerr = rerr_nx;
                n_drow = row_kept ? c_drow + 9'd1 : c_drow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_cerr <= '0;
            r_rerr <= '0;
            r_dcol <= '0;
            r_drow <= '0;
            r_pack <= '0;
        end else if (i_fire) begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_cerr <= n_cerr;
            r_rerr <= n_rerr;
            r_dcol <= n_dcol;
            r_drow <= n_drow;
            r_pack <= n_pack;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nearest_downscale_pixel_packer_core.sv =====
// Nearest-neighbour downscaler and pixel packer.
// Source pixels (8-bit palette indexes) arrive in raster order on the s_axis
// channel, one beat per pixel; tuser flags the first pixel of a frame and
// clears all scan state before that pixel is taken. Kept pixels are packed
// four to a 32-bit word, leftmost in the low byte, and each full word leaves
// on m_axis with its framebuffer word address; tlast marks the last word of
// the destination frame. Geometry is set over the APB port; the user must
// write it only while idle, as the block itself does not enforce this.
// A beat accepted on s_axis is held in the input register, worked on by the
// scaler step, and each finished word is loaded into the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// update of the scan counters and error accumulators, which each pixel reads
// from its predecessor. Reset (synchronous, active low) loads the default
// geometry (320x200 source, 96x64 destination, 128-byte stride) and clears
// the scan state and both beat registers. When the receiver stalls, the held
// output word blocks every update; the input register keeps its beat or takes
// one if empty, then s_axis_tready stays low until the output is taken.
// ----------------------------------------------------------------------------
// nearest_downscale_pixel_packer_core
// Top level: input register, scaler step, output register, APB registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_downscale_pixel_packer_core_macros.svh"

module nearest_downscale_pixel_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] frame_start
    // packed word stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] packed_word, [47:32] word_address
    output logic        m_axis_tlast,   // frame_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ndpp_pkg::*;

    t_cfg        cfg;
    t_result     result;

    logic        r_in_valid;
    logic [7:0]  r_in_pixel;
    logic        r_in_start;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [15:0] r_out_addr;
    logic        r_out_done;

    logic        out_free;
    logic        fire;
    logic        in_beat;

    ndpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // advance the held pixel whenever the output register has room
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    ndpp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_pixel  (r_in_pixel),
        .i_start  (r_in_start),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_pixel <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    // output register: load a finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.emit) begin
            r_out_word <= result.word;
            r_out_addr <= result.addr;
            r_out_done <= result.done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_addr, r_out_word};
    assign m_axis_tlast  = r_out_done;

    // a held word is never overwritten
    `NDPP_ASSERT_SAME(a_no_overwrite, r_out_valid && !m_axis_tready, !fire)
    // a pixel that cannot advance stays in the input register
    `NDPP_ASSERT_NEXT(a_in_hold, r_in_valid && !fire, r_in_valid)
    // every emitted word reaches the output register
    `NDPP_ASSERT_NEXT(a_emit_loads, fire && result.emit, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbour downscaler and pixel packer.
// A queue of source pixels feeds a stream driver, and every accepted beat runs
// through a scan predictor that builds the framebuffer words due. The monitor
// pairs each output beat with the oldest word due. Geometry is reprogrammed
// over APB between phases, with directed corners followed by random frames.
// ----------------------------------------------------------------------------
module tb_top;
    import ndpp_pkg::*;

    typedef struct packed {
        logic [7:0] pix;
        logic       sof;    // frame start flag, travels on tuser
        logic       hold;   // wait for every word due before sending this one
    } t_src_pixel;

    typedef struct packed {
        logic [31:0] word;
        logic [15:0] addr;
        logic        done;
    } t_fb_word;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] pixel
    logic        s_axis_tuser  = 1'b0;  // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [31:0] packed_word, [47:32] word_address
    logic        m_axis_tlast;          // frame_done
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies as written (unclamped), and the scan state they drive
    logic [10:0] geo_src_w;
    logic [10:0] geo_src_h;
    logic [6:0]  geo_words;
    logic [8:0]  geo_dst_h;
    logic [3:0]  geo_shift;

    logic [9:0]  scan_col;
    logic [9:0]  scan_row;
    logic [12:0] col_acc;
    logic [12:0] row_acc;
    logic [8:0]  out_col;
    logic [8:0]  out_row;
    logic [23:0] pack_buf;

    t_src_pixel  pixels_pending[$];
    t_fb_word    words_due[$];

    int  err_count  = 0;
    int  queued     = 0;
    int  tx_gap     = 0;
    int  rx_stall   = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  pix_taken  = 1'b0;

    nearest_downscale_pixel_packer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int bound(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_scan();
        scan_col = '0;
        scan_row = '0;
        col_acc  = '0;
        row_acc  = '0;
        out_col  = '0;
        out_row  = '0;
        pack_buf = '0;
    endtask

    // ------------------------------------------------------------------------
    // Scan predictor: one source pixel in, at most one framebuffer word out.
    // Geometry is clamped here on every pixel, so out-of-range writes and
    // mid-frame changes behave as the block should see them.
    // ------------------------------------------------------------------------
    task automatic downscale_pixel(input logic [7:0] pix, input logic sof);
        int       sw;
        int       sh;
        int       dw;
        int       dh;
        int       sft;
        int       lane;
        int       acc;
        logic     row_kept;
        logic     keep;
        t_fb_word w;
        sw  = bound(geo_src_w, 1, MAX_SOURCE_SIZE);
        sh  = bound(geo_src_h, 1, MAX_SOURCE_SIZE);
        dw  = bound(geo_words, 1, 64) * PIXELS_PER_WORD;
        dh  = bound(geo_dst_h, 1, 256);
        sft = bound(geo_shift, 2, 10);

        // frame start wipes the scan before this pixel is taken
        if (sof) clear_scan();

        // a sample is taken only while both accumulators sit below the
        // destination size and the destination is not yet full
        row_kept = (row_acc < dh) && (out_row < dh);
        keep     = row_kept && (col_acc < dw) && (out_col < dw);

        if (keep) begin
            lane = out_col % PIXELS_PER_WORD;
            if (lane != PIXELS_PER_WORD - 1) begin
                pack_buf = pack_buf | (24'(pix) << (8 * lane));
            end else begin
                w.word = {pix, pack_buf};
                w.addr = 16'(((int'(out_row) << sft) >> 2) + int'(out_col >> 2));
                w.done = (out_row == dh - 1) && (out_col == dw - 1);
                words_due.push_back(w);
                pack_buf = '0;
            end
            out_col = out_col + 9'd1;
        end

        if (int'(scan_col) + 1 >= sw) begin
            // end of source row: drop any half-packed word
            scan_col = '0;
            col_acc  = '0;
            out_col  = '0;
            pack_buf = '0;
            if (int'(scan_row) + 1 >= sh) begin
                clear_scan();
            end else begin
                scan_row = scan_row + 10'd1;
                acc = int'(row_acc);
                if (row_kept) begin
                    acc += sh;
                    out_row = out_row + 9'd1;
                end
                acc -= dh;
                if (acc < 0) acc = 0;
                row_acc = acc[12:0];
            end
        end else begin
            scan_col = scan_col + 10'd1;
            acc = int'(col_acc);
            if (keep) acc += sw;
            acc -= dw;
            if (acc < 0) acc = 0;
            col_acc = acc[12:0];
        end
    endtask

    // ------------------------------------------------------------------------
    // APB write: setup, then access until pready; upper bits carry noise
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        int unsigned mask;
        case (idx)
            REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: mask = 32'h7FF;
            REG_DEST_WORDS:                      mask = 32'h7F;
            REG_DEST_HEIGHT:                     mask = 32'h1FF;
            default:                             mask = 32'hF;
        endcase
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom() & ~mask) | (value & mask);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SOURCE_WIDTH:  geo_src_w = pwdata[10:0];
            REG_SOURCE_HEIGHT: geo_src_h = pwdata[10:0];
            REG_DEST_WORDS:    geo_words = pwdata[6:0];
            REG_DEST_HEIGHT:   geo_dst_h = pwdata[8:0];
            REG_STRIDE_SHIFT:  geo_shift = pwdata[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_geometry(input int sw, input int sh, input int words, input int dh,
                                input int sft, input logic [4:0] which);
        if (which[REG_SOURCE_WIDTH])  write_reg(REG_SOURCE_WIDTH, sw);
        if (which[REG_SOURCE_HEIGHT]) write_reg(REG_SOURCE_HEIGHT, sh);
        if (which[REG_DEST_WORDS])    write_reg(REG_DEST_WORDS, words);
        if (which[REG_DEST_HEIGHT])   write_reg(REG_DEST_HEIGHT, dh);
        if (which[REG_STRIDE_SHIFT])  write_reg(REG_STRIDE_SHIFT, sft);
    endtask

    task automatic queue_pixel(input logic [7:0] pix, input logic sof, input logic hold);
        t_src_pixel p;
        p.pix  = pix;
        p.sof  = sof;
        p.hold = hold;
        pixels_pending.push_back(p);
        queued++;
    endtask

    // A run of random pixels; noisy runs scatter frame starts at random
    task automatic queue_run(input int len, input bit sof_first, input bit noisy);
        for (int i = 0; i < len; i++) begin
            queue_pixel(8'($urandom()),
                        noisy ? 1'($urandom()) : (sof_first && i == 0),
                        $urandom_range(0, 149) == 0);
        end
    endtask

    // Wait until the stream is drained and every word due has been seen, then
    // let the pipeline run on in case the last pixels made no word
    task automatic settle();
        while (pixels_pending.size() != 0 || s_axis_tvalid || words_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: present beats at the falling edge, hold until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_pixels
        t_src_pixel nxt;
        if (i_rst_n && !(s_axis_tvalid && !pix_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pixels_pending.size() != 0 &&
                         !(pixels_pending[0].hold && words_due.size() != 0)) begin
                nxt = pixels_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.pix;
                s_axis_tuser  <= nxt.sof;
                tx_gap = tx_idle_on ? idle_len() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
            rx_stall = idle_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted pixel, check each accepted word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_words
        t_fb_word due;
        pix_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (pix_taken) downscale_pixel(s_axis_tdata, s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (words_due.size() == 0) begin
                $error("unexpected beat: packed_word %h word_address %h frame_done %b",
                       m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tlast);
                err_count++;
            end else begin
                due = words_due.pop_front();
                if (m_axis_tdata[31:0] !== due.word) begin
                    $error("packed_word expected %h got %h", due.word, m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[47:32] !== due.addr) begin
                    $error("word_address expected %h got %h", due.addr, m_axis_tdata[47:32]);
                    err_count++;
                end
                if (m_axis_tlast !== due.done) begin
                    $error("frame_done expected %b got %b", due.done, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int         sw;
        int         sh;
        int         words;
        int         dh;
        int         sft;
        int         full;
        int         budget;
        int         n;
        int         len;
        int         r;
        logic [1:0] mode;
        logic [4:0] which;
        bit         resume;

        geo_src_w = RST_SOURCE_WIDTH;
        geo_src_h = RST_SOURCE_HEIGHT;
        geo_words = RST_DEST_WORDS;
        geo_dst_h = RST_DEST_HEIGHT;
        geo_shift = RST_STRIDE_SHIFT;
        clear_scan();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry: a few pixels at the default 320x200 -> 96x64
        queue_pixel(8'h00, 1'b1, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'h80, 1'b0, 1'b0);
        queue_pixel(8'h7F, 1'b0, 1'b0);
        settle();

        // 4x2 onto one word per row: both rows kept, the second closes the
        // frame; then the scan rolls into a new frame on its own, and a
        // frame start lands part way through it. The first pixel after the
        // frame waits for the words to drain.
        set_geometry(4, 2, 1, 2, 2, 5'h1F);
        queue_pixel(8'h00, 1'b1, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'h00, 1'b0, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'hA5, 1'b0, 1'b0);
        queue_pixel(8'h5A, 1'b0, 1'b0);
        queue_pixel(8'h0F, 1'b0, 1'b0);
        queue_pixel(8'hF0, 1'b0, 1'b0);
        queue_pixel(8'h11, 1'b0, 1'b1);
        queue_pixel(8'h22, 1'b0, 1'b0);
        queue_pixel(8'h33, 1'b1, 1'b0);
        queue_pixel(8'h44, 1'b0, 1'b0);
        queue_pixel(8'h55, 1'b0, 1'b0);
        queue_pixel(8'h66, 1'b0, 1'b0);
        settle();

        // All registers zero: clamp to the low bounds, 1x1 onto 4x1, so every
        // pixel is a whole frame and no word is ever completed
        set_geometry(0, 0, 0, 0, 0, 5'h1F);
        queue_pixel(8'h00, 1'b1, 1'b0);
        queue_pixel(8'hFF, 1'b0, 1'b0);
        queue_pixel(8'h5A, 1'b0, 1'b0);
        queue_pixel(8'hC3, 1'b1, 1'b0);
        settle();

        // Everything above range: clamp to the top, 1024 wide onto 256 wide
        set_geometry(2047, 2047, 127, 511, 15, 5'h1F);
        queue_run(120, 1'b1, 1'b0);
        settle();

        // Tall narrow frame at the widest stride, driving word addresses up to bit 13
        set_geometry(4, 1024, 1, 256, 10, 5'h1F);
        queue_run(520, 1'b1, 1'b0);
        settle();

        // Random phases: mostly whole frames, some cut short, some noise.
        // Now and then only a few registers change and the scan resumes
        // mid-frame under the new geometry.
        while (queued < 1150) begin
            sw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            sh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 19))
                0:       words = 0;
                1:       words = $urandom_range(65, 127);
                default: words = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 19))
                0:       dh = 0;
                1:       dh = $urandom_range(257, 511);
                default: dh = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 19))
                0:       sft = $urandom_range(0, 1);
                1:       sft = $urandom_range(11, 15);
                default: sft = $urandom_range(2, 10);
            endcase
            which  = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'h1F;
            resume = ($urandom_range(0, 3) == 0);
            set_geometry(sw, sh, words, dh, sft, which);

            mode       = 2'($urandom());
            tx_idle_on = mode[0];
            rx_idle_on = mode[1];

            full = bound(geo_src_w, 1, MAX_SOURCE_SIZE) * bound(geo_src_h, 1, MAX_SOURCE_SIZE);
            if (full > 288) full = 288;
            budget = $urandom_range(30, 80);
            n = 0;
            if (resume) begin
                len = $urandom_range(1, full);
                queue_run(len, 1'b0, 1'b0);
                n += len;
            end
            while (n < budget) begin
                r = $urandom_range(0, 99);
                if (r < 75)      len = full;
                else if (r < 90) len = $urandom_range(1, full);
                else             len = $urandom_range(1, 8);
                queue_run(len, 1'b1, r >= 90);
                n += len;
            end
            settle();
        end

        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
